>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property that must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> src/ascon_pkg.sv
// Shared types, constants and the round function for the Ascon-128 engine.
// Depends on nothing; imported by every module of the engine.
package ascon_pkg;

  localparam logic [63:0] IV_WORD = 64'h80400c0600000000;

  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_AD = 3'd1,
    CMD_ENC = 3'd2,
    CMD_DEC = 3'd3,
    CMD_FINISH = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_AD = 3'd1,
    PH_READY = 3'd2,
    PH_OPEN = 3'd3,
    PH_CLOSED = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'd0,
    SEQ_RUN = 2'd1,
    SEQ_OUT = 2'd2,
    SEQ_POST = 2'd3
  } seq_t;

  typedef logic [63:0] lane_t;
  typedef lane_t [4:0] state_t;

  // Control from the sequencer to the permutation unit.
  typedef struct packed {
    logic       load;
    state_t     load_state;
    logic       step;
    logic [3:0] round_idx;
  } perm_ctl_t;

  function automatic lane_t rotr(lane_t v, int n);
    lane_t r;
    r = (v >> n) | (v << (64 - n));
    return r;
  endfunction

  function automatic state_t perm_round(state_t s, logic [3:0] idx);
    state_t x;
    lane_t t0, t1, t2, t3, t4;
    logic [3:0] hi;
    x = s;
    hi = 4'hf - idx;
    x[2] = x[2] ^ {56'd0, hi, idx};
    x[0] = x[0] ^ x[4];
    x[4] = x[4] ^ x[3];
    x[2] = x[2] ^ x[1];
    t0 = ~x[0] & x[1];
    t1 = ~x[1] & x[2];
    t2 = ~x[2] & x[3];
    t3 = ~x[3] & x[4];
    t4 = ~x[4] & x[0];
    x[0] = x[0] ^ t1;
    x[1] = x[1] ^ t2;
    x[2] = x[2] ^ t3;
    x[3] = x[3] ^ t4;
    x[4] = x[4] ^ t0;
    x[1] = x[1] ^ x[0];
    x[0] = x[0] ^ x[4];
    x[3] = x[3] ^ x[2];
    x[2] = ~x[2];
    x[0] = x[0] ^ rotr(x[0], 19) ^ rotr(x[0], 28);
    x[1] = x[1] ^ rotr(x[1], 61) ^ rotr(x[1], 39);
    x[2] = x[2] ^ rotr(x[2], 1) ^ rotr(x[2], 6);
    x[3] = x[3] ^ rotr(x[3], 10) ^ rotr(x[3], 17);
    x[4] = x[4] ^ rotr(x[4], 7) ^ rotr(x[4], 41);
    return x;
  endfunction

  function automatic lane_t head_mask(logic [3:0] n);
    lane_t m;
    m = (n == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n[2:0], 3'b000});
    return m;
  endfunction

  function automatic lane_t pad_bit(logic [3:0] n);
    lane_t p;
    p = 64'h8000000000000000 >> {n[2:0], 3'b000};
    return p;
  endfunction

endpackage

>>> src/ascon_perm.sv
// Permutation unit: holds the 320-bit state and applies one round per step.
// Depends on ascon_pkg.
module ascon_perm (
  input  logic                clk,
  input  ascon_pkg::perm_ctl_t ctl,
  output ascon_pkg::state_t   state
);
  import ascon_pkg::*;

  state_t lanes;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      lanes <= ctl.load_state;
    end else if (ctl.step) begin
      lanes <= perm_round(lanes, ctl.round_idx);
    end
  end

  assign state = lanes;
endmodule

>>> src/ascon128_aead_engine_core.sv
// Ascon-128 AEAD engine. Commands arrive on the in channel (command, block_data,
// second_word, byte_count, final_block); one result per command leaves on the out
// channel (status, data_out, valid_bytes, tag_high, tag_low). The key is written
// through the cfg channel (index 0 key_high, index 1 key_low); the user must write
// it only while idle, as the block itself does not enforce this.
// A transaction that absorbs loads the state, then runs rounds on the single shared
// round unit, one round per cycle: start and finish take INIT_ROUNDS rounds, a full
// data block or an absorbed associated-data block BLOCK_ROUNDS. Start, finish and
// an absorbed final associated-data block apply the key or domain xor in the post
// state after the rounds. The result is offered once the rounds and any xor are
// done; a final message block, an empty associated-data end or an out-of-order
// command offers it in the cycle right after acceptance. The next command is
// accepted the cycle after the result is taken.
// A stalled receiver holds the block with the result steady on the outputs.
// Reset returns the phase to idle and clears the key; every start reloads the lanes.
// Depends on ascon_pkg and ascon_perm.
module ascon128_aead_engine_core #(
  parameter int INIT_ROUNDS = 12,
  parameter int BLOCK_ROUNDS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [63:0] block_data,
  input  logic [63:0] second_word,
  input  logic [3:0]  byte_count,
  input  logic        final_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] data_out,
  output logic [3:0]  valid_bytes,
  output logic [63:0] tag_high,
  output logic [63:0] tag_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import ascon_pkg::*;

  localparam logic [3:0] INIT_START = 4'(12 - INIT_ROUNDS);
  localparam logic [3:0] BLOCK_START = 4'(12 - BLOCK_ROUNDS);

  seq_t seq, seq_next;
  phase_t phase, phase_next;
  logic ad_seen, ad_seen_next, dec_mode, dec_mode_next;
  logic [3:0] round, round_next;
  logic is_finish, is_finish_next, is_start, is_start_next;
  logic is_dsep, is_dsep_next;
  logic [63:0] key_high, key_low;
  logic [1:0] status_r, status_next;
  logic [63:0] dout_r, dout_next, exp_hi, exp_lo, exp_hi_next, exp_lo_next;
  logic [3:0] vb_r, vb_next;
  logic [63:0] th_r, tl_r, th_next, tl_next;
  perm_ctl_t ctl;
  state_t st;
  logic [63:0] m;

  ascon_perm u_perm (.clk(clk), .ctl(ctl), .state(st));

  assign cfg_ready = 1'b1;
  assign in_ready = (seq == SEQ_IDLE);
  assign out_valid = (seq == SEQ_OUT);
  assign status = status_r;
  assign data_out = dout_r;
  assign valid_bytes = vb_r;
  assign tag_high = th_r;
  assign tag_low = tl_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_IDLE;
      phase <= PH_IDLE;
      ad_seen <= 1'b0;
      dec_mode <= 1'b0;
      key_high <= '0;
      key_low <= '0;
    end else begin
      seq <= seq_next;
      phase <= phase_next;
      ad_seen <= ad_seen_next;
      dec_mode <= dec_mode_next;
      if (cfg_valid && !cfg_index) begin
        key_high <= cfg_data;
      end
      if (cfg_valid && cfg_index) begin
        key_low <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    round <= round_next;
    is_finish <= is_finish_next;
    is_start <= is_start_next;
    is_dsep <= is_dsep_next;
    status_r <= status_next;
    dout_r <= dout_next;
    vb_r <= vb_next;
    th_r <= th_next;
    tl_r <= tl_next;
    exp_hi <= exp_hi_next;
    exp_lo <= exp_lo_next;
  end

  always_comb begin
    logic bad, absorb, dec, ph_ok;
    state_t ns;
    seq_next = seq;
    phase_next = phase;
    ad_seen_next = ad_seen;
    dec_mode_next = dec_mode;
    round_next = round;
    is_finish_next = is_finish;
    is_start_next = is_start;
    is_dsep_next = is_dsep;
    status_next = status_r;
    dout_next = dout_r;
    vb_next = vb_r;
    th_next = th_r;
    tl_next = tl_r;
    exp_hi_next = exp_hi;
    exp_lo_next = exp_lo;
    ctl = '{load: 1'b0, load_state: st, step: 1'b0, round_idx: round};
    bad = 1'b0;
    absorb = 1'b0;
    dec = 1'b0;
    ph_ok = 1'b0;
    ns = st;
    m = head_mask(byte_count);
    case (seq)
      SEQ_IDLE: begin
        if (in_valid) begin
          status_next = ST_OK;
          dout_next = '0;
          vb_next = '0;
          th_next = '0;
          tl_next = '0;
          is_finish_next = 1'b0;
          is_start_next = 1'b0;
          is_dsep_next = 1'b0;
          exp_hi_next = block_data;
          exp_lo_next = second_word;
          case (command)
            CMD_START: begin
              ns[0] = IV_WORD;
              ns[1] = key_high;
              ns[2] = key_low;
              ns[3] = block_data;
              ns[4] = second_word;
              absorb = 1'b1;
              round_next = INIT_START;
              is_start_next = 1'b1;
              phase_next = PH_AD;
              ad_seen_next = 1'b0;
              dec_mode_next = 1'b0;
            end
            CMD_AD: begin
              if (phase != PH_AD || (final_block && byte_count > 4'd7)) begin
                bad = 1'b1;
              end else if (!final_block) begin
                ns[0] = st[0] ^ block_data;
                absorb = 1'b1;
                round_next = BLOCK_START;
                ad_seen_next = 1'b1;
              end else begin
                if (byte_count != 4'd0 || ad_seen) begin
                  ns[0] = st[0] ^ (block_data & m) ^ pad_bit(byte_count);
                  absorb = 1'b1;
                  round_next = BLOCK_START;
                  ad_seen_next = 1'b1;
                  is_dsep_next = 1'b1;
                end else begin
                  ns[4] = st[4] ^ 64'd1;
                end
                phase_next = PH_READY;
              end
              // When a final block is absorbed, the domain separation bit goes in after the permutation.
            end
            CMD_ENC, CMD_DEC: begin
              dec = (command == CMD_DEC);
              if (phase == PH_AD && !ad_seen) begin
                ns[4] = st[4] ^ 64'd1;
                ph_ok = 1'b1;
              end else if (phase == PH_READY) begin
                ph_ok = 1'b1;
              end else if (phase == PH_OPEN && dec_mode == dec) begin
                ph_ok = 1'b1;
              end
              if (!ph_ok || (final_block && byte_count > 4'd7)) begin
                bad = 1'b1;
                ns = st;
              end else begin
                dec_mode_next = dec;
                if (!final_block) begin
                  dout_next = st[0] ^ block_data;
                  ns[0] = dec ? block_data : st[0] ^ block_data;
                  vb_next = 4'd8;
                  absorb = 1'b1;
                  round_next = BLOCK_START;
                  phase_next = PH_OPEN;
                end else begin
                  dout_next = (st[0] ^ block_data) & m;
                  if (dec) begin
                    ns[0] = st[0] ^ ((st[0] ^ block_data) & m) ^ pad_bit(byte_count);
                  end else begin
                    ns[0] = st[0] ^ (block_data & m) ^ pad_bit(byte_count);
                  end
                  vb_next = byte_count;
                  phase_next = PH_CLOSED;
                end
              end
            end
            CMD_FINISH: begin
              if (phase != PH_CLOSED) begin
                bad = 1'b1;
              end else begin
                ns[1] = st[1] ^ key_high;
                ns[2] = st[2] ^ key_low;
                absorb = 1'b1;
                round_next = INIT_START;
                is_finish_next = 1'b1;
                phase_next = PH_IDLE;
              end
            end
            default: begin
              bad = 1'b1;
            end
          endcase
          if (bad) begin
            status_next = ST_ORDER;
            dout_next = '0;
            vb_next = '0;
            phase_next = phase;
            ad_seen_next = ad_seen;
            dec_mode_next = dec_mode;
            seq_next = SEQ_OUT;
          end else begin
            ctl.load = 1'b1;
            ctl.load_state = ns;
            seq_next = absorb ? SEQ_RUN : SEQ_OUT;
          end
        end
      end
      SEQ_RUN: begin
        ctl.step = 1'b1;
        round_next = round + 4'd1;
        if (round == 4'd11) begin
          seq_next = (is_start || is_finish || is_dsep) ? SEQ_POST : SEQ_OUT;
        end
      end
      SEQ_POST: begin
        // Key or domain xor that follows the permutation.
        ns = st;
        if (is_dsep) begin
          ns[4] = st[4] ^ 64'd1;
        end else begin
          ns[3] = st[3] ^ key_high;
          ns[4] = st[4] ^ key_low;
        end
        ctl.load = 1'b1;
        ctl.load_state = ns;
        if (is_finish) begin
          th_next = ns[3];
          tl_next = ns[4];
          if (dec_mode && ((ns[3] ^ exp_hi) | (ns[4] ^ exp_lo)) != 64'd0) begin
            status_next = ST_MISMATCH;
          end
        end
        seq_next = SEQ_OUT;
      end
      SEQ_OUT: begin
        if (out_ready) begin
          seq_next = SEQ_IDLE;
        end
      end
      default: begin
        seq_next = SEQ_IDLE;
      end
    endcase
  end
endmodule

>>> src/ascon_checker.sv
// Port-level checker for the Ascon engine, bound to the top level.
// Depends on assert_macros.svh, ascon_pkg and ascon128_aead_engine_core.
`include "assert_macros.svh"
module ascon_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [3:0]  valid_bytes
);
  import ascon_pkg::*;

  `ASSERT_CLK(a_excl, clk, rst, !(in_ready && out_valid), "ready while result pending")
  `ASSERT_CLK(a_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_CLK(a_stat, clk, rst, out_valid |-> (status == ST_OK || status == ST_MISMATCH || status == ST_ORDER), "bad status code")
  `ASSERT_CLK(a_vb, clk, rst, out_valid |-> valid_bytes <= 4'd8, "bad byte count")
  `ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "result after reset")
endmodule

bind ascon128_aead_engine_core ascon_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .valid_bytes(valid_bytes)
);

>>> test/ascon128_aead_engine_core_test.sv
// Self-checking testbench for the Ascon-128 AEAD engine core.
// Drives commands and key writes, predicts every result, compares on the out channel.
// Depends on ascon_pkg and ascon128_aead_engine_core.
`timescale 1ns / 100ps

module ascon128_aead_engine_core_test;
  import ascon_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW = 1'b1;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [3:0]  valid_bytes;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
  } aead_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  command = 3'd0;
  logic [63:0] block_data = '0;
  logic [63:0] second_word = '0;
  logic [3:0]  byte_count = '0;
  logic        final_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [63:0] data_out;
  logic [3:0]  valid_bytes;
  logic [63:0] tag_high;
  logic [63:0] tag_low;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data = '0;

  // Model state.
  lane_t       key_hi_m, key_lo_m;
  lane_t       lanes [5];
  phase_t      phase_m;
  bit          ad_seen_m, dec_mode_m;

  aead_result_t expected_results [$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_cycles = 0;

  always #6 clk = ~clk;

  ascon128_aead_engine_core i_dut (.*);

  function automatic lane_t rot_right(lane_t v, int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  task automatic run_rounds(int rounds);
    lane_t t0, t1, t2, t3, t4;
    logic [3:0] idx;
    for (int r = 12 - rounds; r < 12; r++) begin
      idx = r[3:0];
      lanes[2] ^= {56'd0, 4'd15 - idx, idx};
      lanes[0] ^= lanes[4]; lanes[4] ^= lanes[3]; lanes[2] ^= lanes[1];
      t0 = ~lanes[0] & lanes[1]; t1 = ~lanes[1] & lanes[2];
      t2 = ~lanes[2] & lanes[3]; t3 = ~lanes[3] & lanes[4];
      t4 = ~lanes[4] & lanes[0];
      lanes[0] ^= t1; lanes[1] ^= t2; lanes[2] ^= t3; lanes[3] ^= t4; lanes[4] ^= t0;
      lanes[1] ^= lanes[0]; lanes[0] ^= lanes[4]; lanes[3] ^= lanes[2];
      lanes[2] = ~lanes[2];
      lanes[0] ^= rot_right(lanes[0], 19) ^ rot_right(lanes[0], 28);
      lanes[1] ^= rot_right(lanes[1], 61) ^ rot_right(lanes[1], 39);
      lanes[2] ^= rot_right(lanes[2], 1) ^ rot_right(lanes[2], 6);
      lanes[3] ^= rot_right(lanes[3], 10) ^ rot_right(lanes[3], 17);
      lanes[4] ^= rot_right(lanes[4], 7) ^ rot_right(lanes[4], 41);
    end
  endtask

  function automatic lane_t byte_mask(logic [3:0] n);
    return (n == 0) ? 64'd0 : ~(64'hffffffffffffffff >> (8 * n));
  endfunction

  function automatic lane_t pad_marker(logic [3:0] n);
    return 64'h8000000000000000 >> (8 * n);
  endfunction

  // Computes the result of one command and advances the model state.
  task automatic predict_aead(input logic [2:0] cmd, input lane_t data, input lane_t second,
                              input logic [3:0] cnt, input logic lst);
    aead_result_t res;
    bit order_err, dec;
    lane_t m;
    res = '{ST_ORDER, 64'd0, 4'd0, 64'd0, 64'd0};
    order_err = 1'b0;
    case (cmd)
      CMD_START: begin
        lanes[0] = IV_WORD; lanes[1] = key_hi_m; lanes[2] = key_lo_m;
        lanes[3] = data; lanes[4] = second;
        run_rounds(12);
        lanes[3] ^= key_hi_m; lanes[4] ^= key_lo_m;
        phase_m = PH_AD; ad_seen_m = 0; dec_mode_m = 0;
      end
      CMD_AD: begin
        if (phase_m != PH_AD || (lst && cnt > 7)) begin
          order_err = 1'b1;
        end else if (!lst) begin
          lanes[0] ^= data; run_rounds(6); ad_seen_m = 1;
        end else begin
          if (cnt != 0 || ad_seen_m) begin
            lanes[0] ^= (data & byte_mask(cnt)) ^ pad_marker(cnt);
            run_rounds(6); ad_seen_m = 1;
          end
          lanes[4] ^= 64'd1; phase_m = PH_READY;
        end
      end
      CMD_ENC, CMD_DEC: begin
        dec = (cmd == CMD_DEC);
        if (lst && cnt > 7) order_err = 1'b1;
        else if (phase_m == PH_AD && ad_seen_m) order_err = 1'b1;
        else if (phase_m == PH_OPEN && dec_mode_m != dec) order_err = 1'b1;
        else if (phase_m != PH_AD && phase_m != PH_READY && phase_m != PH_OPEN)
          order_err = 1'b1;
        if (!order_err) begin
          if (phase_m == PH_AD) lanes[4] ^= 64'd1;
          dec_mode_m = dec;
          if (!lst) begin
            if (dec) begin
              res.data_out = lanes[0] ^ data; lanes[0] = data;
            end else begin
              lanes[0] ^= data; res.data_out = lanes[0];
            end
            run_rounds(6); res.valid_bytes = 4'd8; phase_m = PH_OPEN;
          end else begin
            m = byte_mask(cnt);
            if (dec) begin
              res.data_out = (lanes[0] ^ data) & m;
              lanes[0] ^= res.data_out ^ pad_marker(cnt);
            end else begin
              lanes[0] ^= (data & m) ^ pad_marker(cnt);
              res.data_out = lanes[0] & m;
            end
            res.valid_bytes = cnt; phase_m = PH_CLOSED;
          end
        end
      end
      CMD_FINISH: begin
        if (phase_m != PH_CLOSED) begin
          order_err = 1'b1;
        end else begin
          lanes[1] ^= key_hi_m; lanes[2] ^= key_lo_m;
          run_rounds(12);
          lanes[3] ^= key_hi_m; lanes[4] ^= key_lo_m;
          res.tag_high = lanes[3]; res.tag_low = lanes[4];
          phase_m = PH_IDLE;
        end
      end
      default: order_err = 1'b1;
    endcase
    if (!order_err) begin
      res.status = ST_OK;
      if (cmd == CMD_FINISH && dec_mode_m &&
          ((res.tag_high ^ data) | (res.tag_low ^ second)) != 0)
        res.status = ST_MISMATCH;
    end
    expected_results.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Sends one command, predicting it at acceptance.
  task automatic send_command(input logic [2:0] cmd, input lane_t data, input lane_t second,
                              input logic [3:0] cnt, input logic lst);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; command <= cmd; block_data <= data; second_word <= second;
    byte_count <= cnt; final_block <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_aead(cmd, data, second, cnt, lst);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_key(input logic idx, input lane_t value);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_KEY_HIGH) key_hi_m = value;
    else key_lo_m = value;
    @(posedge clk);
  endtask

  function automatic lane_t rand64();
    return {$urandom, $urandom};
  endfunction

  // One well-formed message with random content; the tag is sometimes right.
  task automatic send_message(input bit dec);
    int n_ad, n_msg;
    logic [3:0] cnt;
    send_command(CMD_START, rand64(), rand64(), 4'($urandom_range(15)), 1'($urandom));
    n_ad = $urandom_range(3);
    for (int i = 0; i < n_ad; i++)
      send_command(CMD_AD, rand64(), rand64(), 4'($urandom_range(15)), 1'b0);
    if (n_ad > 0 || $urandom_range(1)) begin
      cnt = 4'($urandom_range(7));
      send_command(CMD_AD, rand64(), rand64(), cnt, 1'b1);
    end
    n_msg = $urandom_range(3);
    for (int i = 0; i < n_msg; i++)
      send_command(dec ? CMD_DEC : CMD_ENC, rand64(), rand64(), 4'($urandom_range(15)), 1'b0);
    send_command(dec ? CMD_DEC : CMD_ENC, rand64(), rand64(), 4'($urandom_range(7)), 1'b1);
    if ($urandom_range(1)) begin
      // Finish with the tag the model computes, so the match path is covered.
      aead_result_t saved;
      lane_t s[5];
      phase_t p;
      s = lanes; p = phase_m;
      predict_aead(CMD_FINISH, 64'd0, 64'd0, 4'd0, 1'b0);
      saved = expected_results.pop_back();
      lanes = s; phase_m = p;
      send_command(CMD_FINISH, saved.tag_high, saved.tag_low, 4'd0, 1'b0);
    end else begin
      send_command(CMD_FINISH, rand64(), rand64(), 4'($urandom_range(15)), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    write_key(CFG_KEY_HIGH, 64'd0);
    write_key(CFG_KEY_LOW, 64'd0);
    send_command(CMD_FINISH, '1, '1, 4'd0, 1'b0);
    send_command(3'd5, '1, '1, 4'd15, 1'b1);
    send_command(3'd7, 64'd0, 64'd0, 4'd0, 1'b0);
    send_command(CMD_START, 64'd0, 64'd0, 4'd0, 1'b0);
    send_command(CMD_AD, 64'd0, 64'd0, 4'd0, 1'b1);
    send_command(CMD_ENC, '1, 64'd0, 4'd0, 1'b1);
    send_command(CMD_FINISH, 64'd0, 64'd0, 4'd0, 1'b0);
    wait_drained();
    write_key(CFG_KEY_HIGH, '1);
    write_key(CFG_KEY_LOW, '1);
    send_command(CMD_START, '1, '1, 4'd0, 1'b0);
    send_command(CMD_AD, '1, 64'd0, 4'd8, 1'b0);
    send_command(CMD_ENC, '1, 64'd0, 4'd0, 1'b0);
    send_command(CMD_AD, '1, 64'd0, 4'd8, 1'b1);
    send_command(CMD_ENC, 64'h0123456789abcdef, 64'd0, 4'd3, 1'b0);
    send_command(CMD_DEC, '1, 64'd0, 4'd0, 1'b1);
    send_command(CMD_ENC, '1, 64'd0, 4'd8, 1'b1);
    send_command(CMD_ENC, 64'hfedcba9876543210, 64'd0, 4'd7, 1'b1);
    send_command(CMD_START, 64'h5555, 64'haaaa, 4'd0, 1'b0);
    send_command(CMD_AD, 64'h1122, 64'd0, 4'd0, 1'b0);
    send_command(CMD_DEC, 64'h3344, 64'd0, 4'd0, 1'b0);
    send_command(CMD_AD, 64'h1122334455667788, 64'd0, 4'd0, 1'b1);
    send_command(CMD_DEC, 64'h99, 64'd0, 4'd5, 1'b1);
    send_command(CMD_FINISH, '1, 64'd0, 4'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
    write_key(CFG_KEY_HIGH, rand64());
    write_key(CFG_KEY_LOW, rand64());
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) send_message(1'($urandom));
      else send_command(3'($urandom), rand64(), rand64(), 4'($urandom_range(15)), 1'($urandom));
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 200;
    for (int i = 0; i < 4; i++) send_message(1'b0);
    wait_drained();
  endtask

  // Receiver side: random stalls plus an occasional long hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    aead_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", {62'd0, status}, 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", 64'(status), 64'(want.status));
        if (data_out !== want.data_out) report_mismatch("data_out", data_out, want.data_out);
        if (valid_bytes !== want.valid_bytes)
          report_mismatch("valid_bytes", 64'(valid_bytes), 64'(want.valid_bytes));
        if (tag_high !== want.tag_high) report_mismatch("tag_high", tag_high, want.tag_high);
        if (tag_low !== want.tag_low) report_mismatch("tag_low", tag_low, want.tag_low);
      end
    end
  end

  // Watchdog over cycles in which no transaction happens on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ascon128_aead_engine_core_test failed");
      $finish;
    end
  end

  initial begin
    lanes = '{default: 64'd0};
    key_hi_m = '0; key_lo_m = '0;
    phase_m = PH_IDLE; ad_seen_m = 0; dec_mode_m = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 30);
    test_random_phase(46, 0, 30);
    test_random_phase(0, 46, 30);
    test_random_phase(32, 32, 30);
    test_backpressure();
    if (error_count == 0) begin
      $display("ascon128_aead_engine_core_test passed");
    end else begin
      $display("ascon128_aead_engine_core_test failed");
    end
    $finish;
  end

endmodule
